### rtl/lunp_pkg.sv
// Shared widths, character codes and base settings for the number parser.
package lunp_pkg;

   localparam int CharWidth  = 8;
   localparam int BaseWidth  = 5;
   localparam int ValueBits  = 32;
   localparam int ValueWidth = ValueBits - 1;
   localparam int DigitWidth = 4;

   localparam logic [CharWidth-1:0] CharNul     = 8'h00;
   localparam logic [CharWidth-1:0] CharTab     = 8'h09;
   localparam logic [CharWidth-1:0] CharSpace   = 8'h20;
   localparam logic [CharWidth-1:0] CharMinus   = 8'h2D;
   localparam logic [CharWidth-1:0] CharZero    = 8'h30;
   localparam logic [CharWidth-1:0] CharSeven   = 8'h37;
   localparam logic [CharWidth-1:0] CharNine    = 8'h39;
   localparam logic [CharWidth-1:0] CharUpperA  = 8'h41;
   localparam logic [CharWidth-1:0] CharUpperF  = 8'h46;
   localparam logic [CharWidth-1:0] CharUpperX  = 8'h58;
   localparam logic [CharWidth-1:0] CharLowerA  = 8'h61;
   localparam logic [CharWidth-1:0] CharLowerF  = 8'h66;
   localparam logic [CharWidth-1:0] CharLowerX  = 8'h78;

   localparam logic [BaseWidth-1:0] BaseAuto    = 5'd0;
   localparam logic [BaseWidth-1:0] BaseOctal   = 5'd8;
   localparam logic [BaseWidth-1:0] BaseDecimal = 5'd10;
   localparam logic [BaseWidth-1:0] BaseHex     = 5'd16;

   localparam logic [BaseWidth-1:0] BaseReset   = BaseDecimal;

endpackage

### rtl/lunp_if.sv
// Valid/ready channels carrying characters in and parse results out.
interface lunp_req_if;
   logic                           valid;
   logic                           ready;
   logic [lunp_pkg::CharWidth-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface lunp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            success;
   logic [lunp_pkg::ValueWidth-1:0] number_value;

   modport source (output valid, output success, output number_value, input ready);
   modport sink   (input valid, input success, input number_value, output ready);
endinterface

### rtl/lenient_unsigned_number_parser.sv
// Streaming ASCII integer parser with auto, octal, decimal and hex bases.
// A NUL waits in the input register for a free result slot, then its result
// is registered. One character per cycle unless a NUL stalls; the shift-add
// accumulator update (radix multiply plus digit) is one stage from the input
// register to the parse state; the result register frees the input side.
// Reset (synchronous, active high): empty pipeline, base 10, parse cleared.
module lenient_unsigned_number_parser (
   input  logic                              clock,
   input  logic                              reset,
   lunp_req_if.sink                          req_chan,
   lunp_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [lunp_pkg::BaseWidth-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_START,
      PH_ZERO,
      PH_FIRST,
      PH_DIGITS,
      PH_TRAIL,
      PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   logic [lunp_pkg::BaseWidth-1:0]  base_ff;
   logic                            in_valid_ff;
   logic [lunp_pkg::CharWidth-1:0]  char_ff;
   phase_type                       phase_ff, phase_in;
   logic                            minus_ff, minus_in;
   radix_type                       radix_ff, radix_in;
   logic [lunp_pkg::ValueBits-1:0]  acc_ff, acc_in;
   logic                            out_valid_ff;
   logic                            success_ff, success_in;
   logic [lunp_pkg::ValueWidth-1:0] value_ff, value_in;

   logic                            is_nul;
   logic                            is_blank;
   logic                            in_advance;
   logic                            nul_fire;
   logic                            out_free;
   logic                            start_step;
   logic                            do_digit;
   logic                            first_req;
   logic                            digit_ok;
   logic [lunp_pkg::DigitWidth-1:0] digit_val;
   logic [lunp_pkg::ValueBits-1:0]  acc_scaled;
   logic [lunp_pkg::ValueBits-1:0]  final_val;
   logic                            ok;

   assign is_nul     = (char_ff == lunp_pkg::CharNul);
   assign is_blank   = (char_ff == lunp_pkg::CharSpace) || (char_ff == lunp_pkg::CharTab);
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   // a NUL needs the result slot; other characters only touch parse state
   assign in_advance = in_valid_ff && (!is_nul || out_free);
   assign nul_fire   = in_advance && is_nul;

   assign req_chan.ready        = !in_valid_ff || in_advance;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.success      = success_ff;
   assign rsp_chan.number_value = value_ff;

   // next parse state for a non-NUL character
   always_comb begin
      phase_in   = phase_ff;
      minus_in   = minus_ff;
      radix_in   = radix_ff;
      acc_in     = acc_ff;
      start_step = 1'b0;
      do_digit   = 1'b0;
      first_req  = 1'b0;
      digit_ok   = 1'b0;
      digit_val  = '0;
      acc_scaled = '0;

      unique case (phase_ff)
         PH_LEAD: begin
            if (is_blank) begin
               phase_in = PH_LEAD;
            end else if (char_ff == lunp_pkg::CharMinus) begin
               minus_in = 1'b1;
               phase_in = PH_START;
            end else begin
               start_step = 1'b1;
            end
         end
         PH_START: begin
            start_step = 1'b1;
         end
         PH_ZERO: begin
            if (char_ff == lunp_pkg::CharLowerX || char_ff == lunp_pkg::CharUpperX) begin
               radix_in = RADIX_HEX;
               phase_in = PH_FIRST;
            end else if (radix_ff == RADIX_OCT) begin
               // the leading 0 adds nothing to a zero accumulator
               do_digit = 1'b1;
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_FIRST: begin
            do_digit  = 1'b1;
            first_req = 1'b1;
         end
         PH_DIGITS: begin
            do_digit = 1'b1;
         end
         PH_TRAIL: begin
            if (!is_blank) begin
               phase_in = PH_FAIL;
            end
         end
         default: begin
            phase_in = PH_FAIL;
         end
      endcase

      // radix choice on the first character after blanks and sign
      if (start_step) begin
         if (char_ff == lunp_pkg::CharZero &&
             (base_ff == lunp_pkg::BaseAuto || base_ff == lunp_pkg::BaseHex)) begin
            radix_in = (base_ff == lunp_pkg::BaseAuto) ? RADIX_OCT : RADIX_HEX;
            phase_in = PH_ZERO;
         end else if (char_ff == lunp_pkg::CharZero && base_ff == lunp_pkg::BaseOctal) begin
            radix_in  = RADIX_OCT;
            do_digit  = 1'b1;
            first_req = 1'b1;
         end else if (base_ff == lunp_pkg::BaseDecimal || base_ff == lunp_pkg::BaseAuto) begin
            radix_in  = RADIX_DEC;
            do_digit  = 1'b1;
            first_req = 1'b1;
         end else begin
            phase_in = PH_FAIL;
         end
      end

      // digit decode in the radix now in use
      priority if (char_ff >= lunp_pkg::CharZero && char_ff <= lunp_pkg::CharSeven) begin
         digit_ok  = 1'b1;
         digit_val = lunp_pkg::DigitWidth'(char_ff - lunp_pkg::CharZero);
      end else if (char_ff >= lunp_pkg::CharZero && char_ff <= lunp_pkg::CharNine) begin
         digit_ok  = (radix_in != RADIX_OCT);
         digit_val = lunp_pkg::DigitWidth'(char_ff - lunp_pkg::CharZero);
      end else if (char_ff >= lunp_pkg::CharLowerA && char_ff <= lunp_pkg::CharLowerF) begin
         digit_ok  = (radix_in == RADIX_HEX);
         digit_val = lunp_pkg::DigitWidth'(char_ff - lunp_pkg::CharLowerA + 8'd10);
      end else if (char_ff >= lunp_pkg::CharUpperA && char_ff <= lunp_pkg::CharUpperF) begin
         digit_ok  = (radix_in == RADIX_HEX);
         digit_val = lunp_pkg::DigitWidth'(char_ff - lunp_pkg::CharUpperA + 8'd10);
      end else begin
         digit_ok  = 1'b0;
      end

      unique case (radix_in)
         RADIX_OCT: acc_scaled = acc_ff << 3;
         RADIX_HEX: acc_scaled = acc_ff << 4;
         default:   acc_scaled = (acc_ff << 3) + (acc_ff << 1);
      endcase

      if (do_digit) begin
         if (!first_req && is_blank) begin
            phase_in = PH_TRAIL;
         end else if (!digit_ok) begin
            phase_in = PH_FAIL;
         end else begin
            acc_in   = acc_scaled + lunp_pkg::ValueBits'(digit_val);
            phase_in = PH_DIGITS;
         end
      end
   end

   // result for a NUL
   always_comb begin
      if (phase_ff == PH_ZERO) begin
         ok = (radix_ff == RADIX_OCT);
      end else begin
         ok = (phase_ff == PH_DIGITS) || (phase_ff == PH_TRAIL);
      end
      final_val  = minus_ff ? (~acc_ff + 1'b1) : acc_ff;
      success_in = ok && !final_val[lunp_pkg::ValueBits-1];
      value_in   = success_in ? final_val[lunp_pkg::ValueWidth-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= lunp_pkg::BaseReset;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD;
         minus_ff     <= 1'b0;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (nul_fire) begin
            out_valid_ff <= 1'b1;
            success_ff   <= success_in;
            value_ff     <= value_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (nul_fire) begin
            phase_ff <= PH_LEAD;
            minus_ff <= 1'b0;
            radix_ff <= RADIX_DEC;
            acc_ff   <= '0;
         end else if (in_advance) begin
            phase_ff <= phase_in;
            minus_ff <= minus_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         char_ff <= req_chan.character;
      end
   end

   a_result_from_nul: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(nul_fire))
      else $error("result appeared without a NUL transfer");

   a_clear_after_nul: assert property (@(posedge clock) disable iff (reset)
      nul_fire |=> (phase_ff == PH_LEAD) && (acc_ff == '0) && !minus_ff)
      else $error("parse state not cleared after NUL");

   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !success_ff |-> (value_ff == '0))
      else $error("failed result carries a nonzero value");

   a_lead_is_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEAD) |-> (acc_ff == '0) && !minus_ff && (radix_ff == RADIX_DEC))
      else $error("leading blank phase holds stale parse state");

endmodule
